// File: rtl/core/oid_bh_pkg.sv
`default_nettype none
package oid_bh_pkg;

  // hash constants
  localparam logic [31:0] HASH_INIT     = 32'h9E37_79B9;
  localparam logic [31:0] HASH_MIX      = 32'h85EB_CA6B;
  localparam logic [31:0] HASH_FINAL    = 32'h7FEB_352D;
  localparam int unsigned SHIFT_ROUND   = 13;
  localparam int unsigned SHIFT_FIN_A   = 16;
  localparam int unsigned SHIFT_FIN_B   = 15;
  localparam logic [31:0] BUCKETS_RESET = 32'd1024;
  localparam int unsigned ID_BYTES_DEF  = 20;

  // one absorbed identifier waiting for finalisation
  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] count;
  } q_entry_t;

  // front to queue write side
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  // queue to back read side
  typedef struct packed {
    logic     empty;
    q_entry_t entry;
  } q_head_t;

endpackage
`default_nettype wire

// File: rtl/core/oid_bh_front.sv
`default_nettype none
module oid_bh_front import oid_bh_pkg::*; #(
  parameter int unsigned ID_BYTES = ID_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  id_byte_i,
  input  wire logic [31:0] bucket_count_i,
  input  wire logic        q_full_i,
  output q_push_t          q_push_o
);

  localparam int unsigned POS_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(ID_BYTES - 1);

  logic [31:0]      hash_q, hash_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             is_last;
  logic             accept;
  logic [31:0]      mixed;
  logic [31:0]      prod;
  logic [31:0]      absorbed;

  // absorb one byte: xor, multiply, shift-xor
  always_comb begin
    mixed    = hash_q ^ {24'b0, id_byte_i};
    prod     = mixed * HASH_MIX;
    absorbed = prod ^ (prod >> SHIFT_ROUND);
  end

  // stall only the last word of an identifier while the queue is full
  assign is_last    = (pos_q == POS_LAST);
  assign in_stall_o = is_last && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // push the absorbed hash with the count in force at the last word
  always_comb begin
    q_push_o.push        = accept && is_last;
    q_push_o.entry.hash  = absorbed;
    q_push_o.entry.count = bucket_count_i;
  end

  // advance position, restart after the last word
  always_comb begin
    hash_d = hash_q;
    pos_d  = pos_q;
    if (accept) begin
      if (is_last) begin
        hash_d = HASH_INIT;
        pos_d  = '0;
      end else begin
        hash_d = absorbed;
        pos_d  = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HASH_INIT;
      pos_q  <= '0;
    end else begin
      hash_q <= hash_d;
      pos_q  <= pos_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/oid_bh_queue.sv
`default_nettype none
module oid_bh_queue import oid_bh_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  q_push_t   q_push_i,
  input  wire logic pop_i,
  output logic      full_o,
  output q_head_t   head_o
);

  q_entry_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o       = (fill_q == 2'd2);
  assign head_o.empty = (fill_q == 2'd0);
  assign head_o.entry = mem_q[rd_ptr_q];

  // store pushed words
  always_ff @(posedge clk_i) begin
    if (q_push_i.push) begin
      mem_q[wr_ptr_q] <= q_push_i.entry;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (q_push_i.push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({q_push_i.push, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/oid_bh_back.sv
`default_nettype none
module oid_bh_back import oid_bh_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  q_head_t     head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output logic [31:0] bucket_num_o,
  output logic [31:0] hash_word_o
);

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [31:0]      ent_hash_q;
  logic [31:0]      count_q;
  logic [31:0]      hash_q;
  logic [31:0]      dvd_q;
  logic [31:0]      rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic [31:0]      index_q;
  logic [31:0]      word_q;

  logic [31:0] fin_a;
  logic [31:0] fin_p;
  logic [31:0] fin_h;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [31:0] rem_next;
  logic        out_free;

  // finalise: shift-xor, multiply, shift-xor
  always_comb begin
    fin_a = ent_hash_q ^ (ent_hash_q >> SHIFT_FIN_A);
    fin_p = fin_a * HASH_FINAL;
    fin_h = fin_p ^ (fin_p >> SHIFT_FIN_B);
  end

  // one restoring step of the modulo
  always_comb begin
    rem_sh   = {rem_q, dvd_q[31]};
    rem_sub  = rem_sh - {1'b0, count_q};
    rem_next = (rem_sh >= {1'b0, count_q}) ? rem_sub[31:0] : rem_sh[31:0];
  end

  assign pop_o    = (state_q == S_IDLE) && !head_i.empty;
  assign out_free = !out_valid_q || !out_stall_i;

  // sequence one identifier through finalise, modulo and output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ent_hash_q  <= '0;
      count_q     <= '0;
      hash_q      <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      index_q     <= '0;
      word_q      <= '0;
    end else begin
      // drop the taken word unless a new one is loaded below
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!head_i.empty) begin
            ent_hash_q <= head_i.entry.hash;
            count_q    <= head_i.entry.count;
            state_q    <= S_MUL;
          end
        end
        S_MUL: begin
          hash_q  <= fin_h;
          dvd_q   <= fin_h;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= rem_next;
          dvd_q <= {dvd_q[30:0], 1'b0};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            index_q     <= (count_q == '0) ? '0 : rem_q;
            word_q      <= hash_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bucket_num_o = index_q;
  assign hash_word_o  = word_q;

endmodule
`default_nettype wire

// File: rtl/core/oid_bucket_hash.sv
// Path from the word carrying the last identifier byte to out_valid_o:
//   (queue pop, finalise multiply, a 32-step restoring modulo, output load).
// Throughput: one byte per cycle unless a full queue stalls it; the back end runs its
//   bit-serial modulo to the end before its next pop; a two-entry queue decouples them.
// Reset: asynchronous active low; clears the running hash to 0x9E3779B9, drops any
//   partial identifier and queued work, and returns the bucket count to 1024.
`default_nettype none
module oid_bucket_hash import oid_bh_pkg::*; #(
  parameter int unsigned ID_BYTES = ID_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  id_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      bucket_num_o,
  output logic [31:0]      hash_word_o
);

  logic [31:0] bucket_count_q;
  q_push_t     q_push;
  q_head_t     q_head;
  logic        q_full;
  logic        q_pop;

  // hold the bucket count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BUCKETS_RESET;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  oid_bh_front #(
    .ID_BYTES (ID_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .id_byte_i      (id_byte_i),
    .bucket_count_i (bucket_count_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push)
  );

  oid_bh_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_push_i (q_push),
    .pop_i    (q_pop),
    .full_o   (q_full),
    .head_o   (q_head)
  );

  oid_bh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bucket_num_o (bucket_num_o),
    .hash_word_o  (hash_word_o)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push.push |-> !q_full)
    else $error("queue written while full");

  // queue never read while empty
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_head.empty)
    else $error("queue read while empty");

  // input stalls only on back pressure from a full queue
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full)
    else $error("input stalled without a full queue");

endmodule
`default_nettype wire
